[src/rgcl_pkg.sv]
package rgcl_pkg;

   localparam int DEF_MAX_CELLS_X  = 128;
   localparam int DEF_MAX_CELLS_Y  = 128;
   localparam int DEF_MAX_LAYERS_Z = 64;

   localparam int SURFACE_DEPTH = 16384;
   localparam int SURFACE_AW    = 14;

   // shared divider: 21-bit dividend (cell number, then column cell index) over a 16-bit divisor
   localparam int DIV_NW    = 21;
   localparam int DIV_DW    = 16;
   localparam int DIV_CNT_W = 5;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd21;

   localparam logic [2:0] KIND_LOAD_X   = 3'd0;
   localparam logic [2:0] KIND_LOAD_Y   = 3'd1;
   localparam logic [2:0] KIND_LOAD_Z   = 3'd2;
   localparam logic [2:0] KIND_SURFACE  = 3'd3;
   localparam logic [2:0] KIND_QUERY    = 3'd4;

   localparam logic [2:0] CSR_COUNT_X     = 3'd0;
   localparam logic [2:0] CSR_COUNT_Y     = 3'd1;
   localparam logic [2:0] CSR_COUNT_Z     = 3'd2;
   localparam logic [2:0] CSR_ORIGIN_X    = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_Y    = 3'd4;
   localparam logic [2:0] CSR_ORIGIN_Z    = 3'd5;
   localparam logic [2:0] CSR_USE_SURFACE = 3'd6;

   typedef struct packed {
      logic [2:0]         kind;
      logic [13:0]        entry_index;
      logic signed [31:0] load_value;
      logic [20:0]        cell_number;
   } req_type;

   typedef struct packed {
      logic               in_range;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] center_z;
      logic signed [31:0] width_x;
      logic signed [31:0] width_y;
      logic signed [31:0] width_z;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mul1;
      logic mul2;
      logic check;
      logic div_start;
      logic div_sel;
      logic take_k;
      logic take_j;
      logic mem_read;
      logic rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic req_is_query;
      logic range_ok;
      logic div_done;
      logic div_busy;
      logic rsp_free;
   } ctrl_status_type;

   function automatic logic [31:0] half_q(input logic [31:0] v);
      half_q = {v[31], v[31:1]};
   endfunction

endpackage

[src/rgcl_divider.sv]
module rgcl_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [rgcl_pkg::DIV_NW-1:0] dividend,
   input  logic [rgcl_pkg::DIV_DW-1:0] divisor,
   output logic                       busy,
   output logic                       done,
   output logic [rgcl_pkg::DIV_NW-1:0] quotient,
   output logic [rgcl_pkg::DIV_DW-1:0] remainder
);
   import rgcl_pkg::*;

   logic [DIV_NW-1:0]    quot_ff, quot_in;
   logic [DIV_DW-1:0]    rem_ff, rem_in;
   logic [DIV_DW-1:0]    dvs_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DW:0]      shifted;
   logic [DIV_DW:0]      trial;
   logic                 ge;

   // restoring radix-2, one quotient bit per cycle
   assign shifted = {rem_ff, quot_ff[DIV_NW-1]};
   assign trial   = shifted - {1'b0, dvs_ff};
   assign ge      = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         cnt_in  = DIV_STEPS;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         quot_in = {quot_ff[DIV_NW-2:0], ge};
         rem_in  = ge ? trial[DIV_DW-1:0] : shifted[DIV_DW-1:0];
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

[src/rgcl_datapath.sv]
module rgcl_datapath #(
   parameter int MAX_CELLS_X  = rgcl_pkg::DEF_MAX_CELLS_X,
   parameter int MAX_CELLS_Y  = rgcl_pkg::DEF_MAX_CELLS_Y,
   parameter int MAX_LAYERS_Z = rgcl_pkg::DEF_MAX_LAYERS_Z
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rgcl_pkg::req_type         req_data,
   output rgcl_pkg::rsp_type         rsp_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic                      csr_valid,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data,
   input  rgcl_pkg::ctrl_cmd_type    cmd,
   output rgcl_pkg::ctrl_status_type status
);
   import rgcl_pkg::*;

   localparam int XW = (MAX_CELLS_X  > 1) ? $clog2(MAX_CELLS_X)  : 1;
   localparam int YW = (MAX_CELLS_Y  > 1) ? $clog2(MAX_CELLS_Y)  : 1;
   localparam int ZW = (MAX_LAYERS_Z > 1) ? $clog2(MAX_LAYERS_Z) : 1;
   localparam logic [13:0] LIM_X = 14'(MAX_CELLS_X);
   localparam logic [13:0] LIM_Y = 14'(MAX_CELLS_Y);
   localparam logic [13:0] LIM_Z = 14'(MAX_LAYERS_Z);

   // configuration
   logic [7:0]  count_x_ff, count_y_ff;
   logic [6:0]  count_z_ff;
   logic [31:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic        use_surface_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff     <= 8'd1;
         count_y_ff     <= 8'd1;
         count_z_ff     <= 7'd1;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         origin_z_ff    <= '0;
         use_surface_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COUNT_X:     count_x_ff     <= csr_data[7:0];
            CSR_COUNT_Y:     count_y_ff     <= csr_data[7:0];
            CSR_COUNT_Z:     count_z_ff     <= csr_data[6:0];
            CSR_ORIGIN_X:    origin_x_ff    <= csr_data;
            CSR_ORIGIN_Y:    origin_y_ff    <= csr_data;
            CSR_ORIGIN_Z:    origin_z_ff    <= csr_data;
            CSR_USE_SURFACE: use_surface_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // table loads, each taken in its accept cycle
   logic [31:0] edge_ff [3];
   logic [31:0] base_x, base_y, base_z;
   logic        wr_x, wr_y, wr_z, wr_s;
   logic [31:0] v;
   logic [13:0] idx;

   assign v   = req_data.load_value;
   assign idx = req_data.entry_index;

   always_comb begin
      wr_x = 1'b0;
      wr_y = 1'b0;
      wr_z = 1'b0;
      wr_s = 1'b0;
      if (cmd.accept) begin
         case (req_data.kind)
            KIND_LOAD_X:  wr_x = (idx < LIM_X);
            KIND_LOAD_Y:  wr_y = (idx < LIM_Y);
            KIND_LOAD_Z:  wr_z = (idx < LIM_Z);
            KIND_SURFACE: wr_s = 1'b1;
            default: ;
         endcase
      end
   end

   assign base_x = (idx == '0) ? origin_x_ff : edge_ff[0];
   assign base_y = (idx == '0) ? origin_y_ff : edge_ff[1];
   assign base_z = (idx == '0) ? origin_z_ff : edge_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff[0] <= '0;
         edge_ff[1] <= '0;
         edge_ff[2] <= '0;
      end else begin
         if (wr_x) edge_ff[0] <= base_x + v;
         if (wr_y) edge_ff[1] <= base_y + v;
         if (wr_z) edge_ff[2] <= base_z + v;
      end
   end

   // {spacing, center} per entry
   logic [63:0] mem_x [MAX_CELLS_X];
   logic [63:0] mem_y [MAX_CELLS_Y];
   logic [63:0] mem_z [MAX_LAYERS_Z];
   logic [31:0] mem_s [SURFACE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_x) mem_x[idx[XW-1:0]] <= {v, base_x + half_q(v)};
      if (wr_y) mem_y[idx[YW-1:0]] <= {v, base_y + half_q(v)};
      if (wr_z) mem_z[idx[ZW-1:0]] <= {v, base_z + half_q(v)};
      if (wr_s) mem_s[idx[SURFACE_AW-1:0]] <= v;
   end

   // query arithmetic
   logic [20:0] n_ff;
   logic [15:0] nh_ff;
   logic [22:0] total_ff;
   logic        ok_ff;
   logic        counts_ok;
   logic [ZW-1:0] k_ff;
   logic [15:0]   h_ff;
   logic [YW-1:0] j_ff;
   logic [XW-1:0] i_ff;

   logic              div_busy, div_done;
   logic [DIV_NW-1:0] div_q;
   logic [DIV_DW-1:0] div_r;
   logic [DIV_NW-1:0] div_n;
   logic [DIV_DW-1:0] div_d;

   assign counts_ok = (count_x_ff != '0) && (count_y_ff != '0) && (count_z_ff != '0)
                      && ({6'b0, count_x_ff} <= LIM_X) && ({6'b0, count_y_ff} <= LIM_Y)
                      && ({7'b0, count_z_ff} <= LIM_Z);

   assign div_n = cmd.div_sel ? {5'b0, h_ff} : n_ff;
   assign div_d = cmd.div_sel ? {8'b0, count_x_ff} : nh_ff;

   rgcl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_n),
      .divisor   (div_d),
      .busy      (div_busy),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_ff @(posedge clock) begin
      if (cmd.accept) n_ff <= req_data.cell_number;
      if (cmd.mul1) nh_ff <= {8'b0, count_x_ff} * {8'b0, count_y_ff};
      if (cmd.mul2) total_ff <= {7'b0, nh_ff} * {16'b0, count_z_ff};
      if (cmd.check) ok_ff <= counts_ok && ({2'b0, n_ff} < total_ff);
      if (cmd.take_k) begin
         k_ff <= div_q[ZW-1:0];
         h_ff <= div_r;
      end
      if (cmd.take_j) begin
         j_ff <= div_q[YW-1:0];
         i_ff <= div_r[XW-1:0];
      end
   end

   logic [63:0] rd_x_ff, rd_y_ff, rd_z_ff;
   logic [31:0] rd_s_ff;

   always_ff @(posedge clock) begin
      if (cmd.mem_read) begin
         rd_x_ff <= mem_x[i_ff];
         rd_y_ff <= mem_y[j_ff];
         rd_z_ff <= mem_z[k_ff];
         rd_s_ff <= mem_s[h_ff[SURFACE_AW-1:0]];
      end
   end

   // result register
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff;

   always_comb begin
      rsp_in = '0;
      if (ok_ff) begin
         rsp_in.in_range = 1'b1;
         rsp_in.center_x = rd_x_ff[31:0];
         rsp_in.center_y = rd_y_ff[31:0];
         rsp_in.center_z = rd_z_ff[31:0] + (use_surface_ff ? rd_s_ff : 32'd0);
         rsp_in.width_x  = rd_x_ff[63:32];
         rsp_in.width_y  = rd_y_ff[63:32];
         rsp_in.width_z  = rd_z_ff[63:32];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   assign status.req_is_query = (req_data.kind == KIND_QUERY);
   assign status.range_ok     = counts_ok && ({2'b0, n_ff} < total_ff);
   assign status.div_done     = div_done;
   assign status.div_busy     = div_busy;
   assign status.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

[src/rgcl_ctrl.sv]
module rgcl_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  rgcl_pkg::ctrl_status_type status,
   output rgcl_pkg::ctrl_cmd_type    cmd
);
   import rgcl_pkg::*;

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL1   = 4'd1;
   localparam logic [3:0] ST_MUL2   = 4'd2;
   localparam logic [3:0] ST_CHECK  = 4'd3;
   localparam logic [3:0] ST_DIV1   = 4'd4;
   localparam logic [3:0] ST_DIV2S  = 4'd5;
   localparam logic [3:0] ST_DIV2   = 4'd6;
   localparam logic [3:0] ST_READ   = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.req_is_query) state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.range_ok) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV1;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV1: begin
            if (status.div_done) begin
               cmd.take_k = 1'b1;
               state_in = ST_DIV2S;
            end
         end
         ST_DIV2S: begin
            cmd.div_sel   = 1'b1;
            cmd.div_start = 1'b1;
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (status.div_done) begin
               cmd.take_j = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.mem_read = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_div_idle_at_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !status.div_busy)
      else $error("divider started while busy");

   a_take_needs_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.take_k || cmd.take_j) |-> status.div_done)
      else $error("quotient taken before divider finished");

   a_rsp_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result overwritten while still pending");

   a_query_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && status.req_is_query) |=> state_ff == ST_MUL1)
      else $error("query request not started");

endmodule

[src/rectilinear_grid_cell_lookup.sv]
// Rectilinear 3-D grid cell lookup.
// Request channel (req_valid/req_ready, req_data): load items write the
// x/y/z spacing tables (center derived from a running edge) or the surface
// offset table; query items map a linear cell number to its cell.
// Response channel (rsp_valid/rsp_ready, rsp_data): one result per query,
// nothing for loads or unused kinds.
// CSR port (csr_valid/csr_ready, csr_index, csr_data): always ready; write
// only while no request is in flight.
// A load is written in its accept cycle and leaves req_ready high. After a
// query is accepted, req_ready stays low until its result is written:
// a multiply for the column cell count, one for the cell total, a range
// check that also starts the divider, two passes through one shared
// radix-2 divider (layer/column, then y/x) with a restart state between
// them, a table read and the result write. Out-of-range queries skip the
// divider; their result has in_range low.
// Reset (synchronous) restores the CSR defaults and clears running edges;
// table contents are undefined until loaded.
// A stalled receiver leaves the result in the output register; loads are
// still taken meanwhile, and the next query waits at its final step.
module rectilinear_grid_cell_lookup #(
   parameter int MAX_CELLS_X  = rgcl_pkg::DEF_MAX_CELLS_X,
   parameter int MAX_CELLS_Y  = rgcl_pkg::DEF_MAX_CELLS_Y,
   parameter int MAX_LAYERS_Z = rgcl_pkg::DEF_MAX_LAYERS_Z
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rgcl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rgcl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import rgcl_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   assign csr_ready = 1'b1;

   rgcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rgcl_datapath #(
      .MAX_CELLS_X  (MAX_CELLS_X),
      .MAX_CELLS_Y  (MAX_CELLS_Y),
      .MAX_LAYERS_Z (MAX_LAYERS_Z)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule

[test/rectilinear_grid_cell_lookup_checker.sv]
`timescale 1ns / 100ps

module rectilinear_grid_cell_lookup_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  rgcl_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  rgcl_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output int                fail_count,
   output int                open_count
);

   import rgcl_pkg::*;

   localparam int PRINT_CAP = 60;

   // grid settings as last written
   logic [7:0]  count_x;
   logic [7:0]  count_y;
   logic [6:0]  count_z;
   logic [31:0] origin [3];
   logic        use_surface;

   // cell tables and per-axis running edges
   logic [31:0] run_edge [3];
   logic [31:0] x_width [DEF_MAX_CELLS_X];
   logic [31:0] x_mid [DEF_MAX_CELLS_X];
   logic [31:0] y_width [DEF_MAX_CELLS_Y];
   logic [31:0] y_mid [DEF_MAX_CELLS_Y];
   logic [31:0] z_width [DEF_MAX_LAYERS_Z];
   logic [31:0] z_mid [DEF_MAX_LAYERS_Z];
   logic [31:0] surface_ofs [SURFACE_DEPTH];

   rsp_type     cell_queue [$];
   int          mismatches = 0;
   int          rsp_seen = 0;

   task automatic report_mismatch(input string what);
      if (mismatches < PRINT_CAP)
         $display("%0t: response %0d: %s", $time, rsp_seen, what);
      mismatches++;
   endtask

   task automatic take_config(input logic [2:0] idx, input logic [31:0] value);
      case (idx)
         CSR_COUNT_X:     count_x = value[7:0];
         CSR_COUNT_Y:     count_y = value[7:0];
         CSR_COUNT_Z:     count_z = value[6:0];
         CSR_ORIGIN_X:    origin[0] = value;
         CSR_ORIGIN_Y:    origin[1] = value;
         CSR_ORIGIN_Z:    origin[2] = value;
         CSR_USE_SURFACE: use_surface = value[0];
         default: ;
      endcase
   endtask

   task automatic apply_request(input req_type r);
      logic [31:0] v;
      logic [31:0] base;
      int unsigned idx, cx, cy, cz, col_cells, n, k, h, i, j;
      rsp_type     pred;
      v = r.load_value;
      idx = 32'(r.entry_index);
      // center = edge + spacing/2 (arithmetic shift), edge restarts at origin on slot 0
      case (r.kind)
         KIND_LOAD_X: if (idx < DEF_MAX_CELLS_X) begin
            base = (idx == 0) ? origin[0] : run_edge[0];
            x_width[idx] = v;
            x_mid[idx] = base + {v[31], v[31:1]};
            run_edge[0] = base + v;
         end
         KIND_LOAD_Y: if (idx < DEF_MAX_CELLS_Y) begin
            base = (idx == 0) ? origin[1] : run_edge[1];
            y_width[idx] = v;
            y_mid[idx] = base + {v[31], v[31:1]};
            run_edge[1] = base + v;
         end
         KIND_LOAD_Z: if (idx < DEF_MAX_LAYERS_Z) begin
            base = (idx == 0) ? origin[2] : run_edge[2];
            z_width[idx] = v;
            z_mid[idx] = base + {v[31], v[31:1]};
            run_edge[2] = base + v;
         end
         KIND_SURFACE: surface_ofs[idx] = v;
         KIND_QUERY: begin
            pred = '0;
            cx = 32'(count_x);
            cy = 32'(count_y);
            cz = 32'(count_z);
            if (cx != 0 && cy != 0 && cz != 0 && cx <= DEF_MAX_CELLS_X &&
                cy <= DEF_MAX_CELLS_Y && cz <= DEF_MAX_LAYERS_Z) begin
               col_cells = cx * cy;
               n = 32'(r.cell_number);
               if (n < col_cells * cz) begin
                  k = n / col_cells;
                  h = n % col_cells;
                  j = h / cx;
                  i = h % cx;
                  pred.in_range = 1'b1;
                  pred.center_x = x_mid[i];
                  pred.center_y = y_mid[j];
                  pred.center_z = z_mid[k] + (use_surface ? surface_ofs[h] : 32'd0);
                  pred.width_x = x_width[i];
                  pred.width_y = y_width[j];
                  pred.width_z = z_width[k];
               end
            end
            cell_queue.push_back(pred);
         end
         default: ;
      endcase
   endtask

   task automatic check_cell(input rsp_type got);
      rsp_type want;
      rsp_seen++;
      if (cell_queue.size() == 0) begin
         report_mismatch("response with no query outstanding");
      end else begin
         want = cell_queue.pop_front();
         if (got.in_range !== want.in_range)
            report_mismatch($sformatf("in_range %b, expected %b", got.in_range, want.in_range));
         if (got.center_x !== want.center_x)
            report_mismatch($sformatf("center_x %h, expected %h", got.center_x, want.center_x));
         if (got.center_y !== want.center_y)
            report_mismatch($sformatf("center_y %h, expected %h", got.center_y, want.center_y));
         if (got.center_z !== want.center_z)
            report_mismatch($sformatf("center_z %h, expected %h", got.center_z, want.center_z));
         if (got.width_x !== want.width_x)
            report_mismatch($sformatf("width_x %h, expected %h", got.width_x, want.width_x));
         if (got.width_y !== want.width_y)
            report_mismatch($sformatf("width_y %h, expected %h", got.width_y, want.width_y));
         if (got.width_z !== want.width_z)
            report_mismatch($sformatf("width_z %h, expected %h", got.width_z, want.width_z));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         count_x = 8'd1;
         count_y = 8'd1;
         count_z = 7'd1;
         use_surface = 1'b0;
         for (int a = 0; a < 3; a++) begin
            origin[a] = '0;
            run_edge[a] = '0;
         end
         cell_queue.delete();
      end else begin
         // a response accepted here always belongs to an earlier query
         if (rsp_valid && rsp_ready)
            check_cell(rsp_data);
         if (csr_valid && csr_ready)
            take_config(csr_index, csr_data);
         if (req_valid && req_ready)
            apply_request(req_data);
      end
      fail_count <= mismatches;
      open_count <= cell_queue.size();
   end

endmodule

[test/rectilinear_grid_cell_lookup_test.sv]
`timescale 1ns / 100ps

module rectilinear_grid_cell_lookup_test;

   import rgcl_pkg::*;

   localparam int ITEM_TARGET   = 1800;
   localparam int QUIET_TAIL    = 300;
   localparam int HOLD_CYCLES   = 250;
   localparam int SETTLE_CYCLES = 64;
   localparam int STALL_LIMIT   = 4000;
   localparam int CELL_NUM_MAX  = 21'h1F_FFFF;

   // kinds the block does not decode
   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = CSR_COUNT_X;
   logic [31:0] csr_data = '0;
   int          fail_count;
   int          open_count;

   // grid as currently programmed, for building legal queries
   int          cx = 1;
   int          cy = 1;
   int          cz = 1;
   bit          surf_loaded [SURFACE_DEPTH];
   bit          idle_on = 1'b0;
   bit          hold_req = 1'b0;
   int          items_sent = 0;
   int          queries_sent = 0;
   int          grids_used = 0;
   int          quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   rectilinear_grid_cell_lookup u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   rectilinear_grid_cell_lookup_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .open_count (open_count)
   );

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
         $display("rectilinear_grid_cell_lookup test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic logic [31:0] q16_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0001;
         4, 5: return $urandom_range(0, 32'h000F_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic int axis_count(input int max_count);
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(1, max_count);
      return $urandom_range(1, 8);
   endfunction

   function automatic bit grid_ok();
      return cx >= 1 && cx <= DEF_MAX_CELLS_X && cy >= 1 && cy <= DEF_MAX_CELLS_Y &&
             cz >= 1 && cz <= DEF_MAX_LAYERS_Z;
   endfunction

   // valid stays high across back-to-back requests; it drops for a gap or when results are drained
   task automatic push_request(input req_type r);
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (idle_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic send_load(input logic [2:0] kind, input int idx, input logic [31:0] value);
      req_type r;
      bit      taken;
      r.kind = kind;
      r.entry_index = 14'(idx);
      r.load_value = value;
      r.cell_number = 21'($urandom_range(0, CELL_NUM_MAX));
      push_request(r);
      case (kind)
         KIND_LOAD_X, KIND_LOAD_Y: taken = idx < DEF_MAX_CELLS_X;
         KIND_LOAD_Z:              taken = idx < DEF_MAX_LAYERS_Z;
         KIND_SURFACE: begin
            taken = 1'b1;
            surf_loaded[idx] = 1'b1;
         end
         default:                  taken = 1'b0;
      endcase
      if (taken)
         items_sent++;
   endtask

   task automatic send_query(input int n);
      req_type r;
      r.kind = KIND_QUERY;
      r.entry_index = 14'($urandom_range(0, SURFACE_DEPTH - 1));
      r.load_value = $urandom;
      r.cell_number = 21'(n);
      push_request(r);
      items_sent++;
      queries_sent++;
   endtask

   // in-range query if the grid is legal, else a random cell number; its column offset is loaded first if never written
   task automatic query_inside();
      int i, j, k, h;
      if (!grid_ok()) begin
         send_query($urandom_range(0, CELL_NUM_MAX));
      end else begin
         i = $urandom_range(0, cx - 1);
         j = $urandom_range(0, cy - 1);
         k = $urandom_range(0, cz - 1);
         if ($urandom_range(0, 7) == 0) begin
            i = cx - 1;
            j = cy - 1;
            k = cz - 1;
         end
         h = j * cx + i;
         if (!surf_loaded[h])
            send_load(KIND_SURFACE, h, q16_value());
         send_query(k * cx * cy + h);
      end
   endtask

   task automatic query_outside();
      int total;
      total = grid_ok() ? cx * cy * cz : 0;
      if ($urandom_range(0, 3) == 0)
         send_query(total);
      else
         send_query($urandom_range(total, CELL_NUM_MAX));
   endtask

   task automatic send_noise();
      logic [2:0] kind;
      int         top_slot;
      kind = 3'(KIND_LOAD_X + $urandom_range(0, 2));
      top_slot = (kind == KIND_LOAD_Z) ? DEF_MAX_LAYERS_Z : DEF_MAX_CELLS_X;
      case ($urandom_range(0, 5))
         0, 1: send_load(kind, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, top_slot - 1),
                         q16_value());
         2: send_load(kind, $urandom_range(top_slot, SURFACE_DEPTH - 1), q16_value());
         3, 4: send_load(KIND_SURFACE, $urandom_range(0, SURFACE_DEPTH - 1), q16_value());
         default: send_load(3'(KIND_SPARE_FIRST + $urandom_range(0, 2)),
                            $urandom_range(0, SURFACE_DEPTH - 1), $urandom);
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_grid(input int nx, input int ny, input int nz, input logic [31:0] ox,
                           input logic [31:0] oy, input logic [31:0] oz, input bit surf);
      drain_results();
      // loads leave no result behind, so give the block time to settle
      repeat (SETTLE_CYCLES) @(posedge clock);
      write_csr(CSR_COUNT_X, nx);
      write_csr(CSR_COUNT_Y, ny);
      write_csr(CSR_COUNT_Z, nz);
      write_csr(CSR_ORIGIN_X, ox);
      write_csr(CSR_ORIGIN_Y, oy);
      write_csr(CSR_ORIGIN_Z, oz);
      write_csr(CSR_USE_SURFACE, 32'(surf));
      csr_valid <= 1'b0;
      cx = nx;
      cy = ny;
      cz = nz;
      grids_used++;
   endtask

   task automatic load_axes();
      for (int a = 0; a < cx && a < DEF_MAX_CELLS_X; a++)
         send_load(KIND_LOAD_X, a, q16_value());
      for (int a = 0; a < cy && a < DEF_MAX_CELLS_Y; a++)
         send_load(KIND_LOAD_Y, a, q16_value());
      for (int a = 0; a < cz && a < DEF_MAX_LAYERS_Z; a++)
         send_load(KIND_LOAD_Z, a, q16_value());
   endtask

   task automatic grid_body(input int steps);
      for (int s = 0; s < steps; s++) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_noise();
            3:       query_outside();
            default: query_inside();
         endcase
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: wrapping centers, rounding of odd negative spacings, edge queries
      set_grid(2, 2, 2, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_8000, 1'b1);
      send_load(KIND_LOAD_X, 0, 32'h7FFF_FFFF);
      send_load(KIND_LOAD_X, 1, 32'h8000_0000);
      send_load(KIND_LOAD_Y, 0, 32'hFFFF_FFFF);
      send_load(KIND_LOAD_Y, 1, 32'h0001_8000);
      send_load(KIND_LOAD_Z, 0, 32'h0001_0001);
      send_load(KIND_LOAD_Z, 1, 32'h0000_0000);
      for (int h = 0; h < 4; h++)
         send_load(KIND_SURFACE, h, q16_value());
      send_load(KIND_SURFACE, SURFACE_DEPTH - 1, 32'h8000_0000);
      send_query(0);
      send_query(7);
      send_query(8);
      send_query(CELL_NUM_MAX);
      for (int s = 0; s < 3; s++)
         send_load(3'(KIND_SPARE_FIRST + s), s, $urandom);
      send_load(KIND_LOAD_X, DEF_MAX_CELLS_X, 32'h0001_0000);
      send_load(KIND_LOAD_Z, DEF_MAX_LAYERS_Z, 32'h0001_0000);
      // out of order: builds on the current edge, not the origin
      send_load(KIND_LOAD_X, 1, 32'h0002_0000);
      send_query(5);

      // back-pressure: results held off while requests keep coming
      idle_on = 1'b1;
      set_grid(5, 3, 4, q16_value(), q16_value(), q16_value(), 1'b1);
      load_axes();
      hold_req = 1'b1;
      grid_body(40);
      drain_results();
      grid_body(40);

      set_grid(DEF_MAX_CELLS_X, DEF_MAX_CELLS_Y, DEF_MAX_LAYERS_Z,
               32'h7FFF_FFFF, 32'h8000_0000, q16_value(), 1'b1);
      load_axes();
      grid_body(150);
      set_grid(0, 255, 127, q16_value(), q16_value(), q16_value(), 1'b0);
      load_axes();
      grid_body(30);
      set_grid(2, 1, 0, q16_value(), q16_value(), q16_value(), 1'b1);
      load_axes();
      grid_body(20);
      set_grid(DEF_MAX_CELLS_X + 1, 1, 1, q16_value(), q16_value(), q16_value(), 1'b0);
      load_axes();
      grid_body(20);
      set_grid(1, 1, 1, 32'h0, 32'h0, 32'h0, 1'b0);
      load_axes();
      grid_body(40);

      while (items_sent < ITEM_TARGET) begin
         idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL) && ($urandom_range(0, 3) != 0);
         set_grid(axis_count(DEF_MAX_CELLS_X), axis_count(DEF_MAX_CELLS_Y),
                  axis_count(DEF_MAX_LAYERS_Z), q16_value(), q16_value(), q16_value(),
                  1'($urandom_range(0, 1)));
         load_axes();
         grid_body($urandom_range(60, 120));
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ran %0d requests (%0d lookups) across %0d grid setups", items_sent,
               queries_sent, grids_used);
      $display("grids ranged from 1x1x1 to 128x128x64, with bad counts and surface on/off");
      if (fail_count == 0 && open_count == 0) begin
         $display("rectilinear_grid_cell_lookup test passed");
      end else begin
         $display("rectilinear_grid_cell_lookup test failed");
      end
      $finish;
   end

endmodule
